FILE: src/bpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_pkg: shared types and constants
// Widths, the ln2 scale factor and the records passed between the units.
// ----------------------------------------------------------------------------
package bpl_pkg;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 56;
  localparam int FRAC_W = 24;
  localparam int K_W    = 6;
  localparam int D_W    = 31;
  localparam int DIG_W  = 16;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef struct packed {
    logic [K_W-1:0]    k;
    logic [FRAC_W-1:0] frac;
  } log_res_t;

  typedef struct packed {
    logic [D_W-1:0]   d;
    logic [CNT_W:0]   tot;
    logic [CNT_W-1:0] b;
    logic [CNT_W-1:0] s;
  } term_op_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sb;
    logic signed [SUM_W-1:0] b;
  } term_res_t;
endpackage

FILE: src/bpl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_if: channel interfaces
// Bin input channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpl_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] back_count;
  logic [31:0] sig_count;
  logic        last_bin;
  modport source (output valid, back_count, sig_count, last_bin, input ready);
  modport sink   (input valid, back_count, sig_count, last_bin, output ready);
endinterface

interface bpl_out_if;
  logic               valid;
  logic               ready;
  logic signed [55:0] sb_sum;
  logic signed [55:0] b_sum;
  logic signed [55:0] delta_llr;
  logic               overflow;
  modport source (output valid, sb_sum, b_sum, delta_llr, overflow, input ready);
  modport sink   (input valid, sb_sum, b_sum, delta_llr, overflow, output ready);
endinterface

FILE: src/bpl_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_log: serial log2 unit
// Normalizes one bit per cycle in a shift register, then squares the
// mantissa once per cycle to produce one fraction bit of log2 (Q6.24).
// ----------------------------------------------------------------------------
module bpl_log (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [32:0]        v,
  output logic               done,
  output bpl_pkg::log_res_t  res
);
  import bpl_pkg::*;

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQR  = 3'b100
  } lstate_t;

  lstate_t           st_r, st_nxt;
  logic [33:0]       sh_r, sh_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [31:0]       m;
  logic [63:0]       sq;
  logic [32:0]       t;

  assign m  = sh_r[33:2];
  assign sq = 64'(m) * 64'(m);
  assign t  = sq[63:31];

  always_comb begin
    st_nxt   = st_r;
    sh_nxt   = sh_r;
    k_nxt    = k_r;
    frac_nxt = frac_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    unique case (st_r)
      L_IDLE: begin
        if (start) begin
          sh_nxt   = {1'b0, v};
          k_nxt    = K_W'(33);
          frac_nxt = '0;
          cnt_nxt  = '0;
          done_nxt = 1'b0;
          st_nxt   = L_NORM;
        end
      end
      L_NORM: begin
        if (sh_r[33]) begin
          st_nxt = L_SQR;
        end else begin
          sh_nxt = {sh_r[32:0], 1'b0};
          k_nxt  = k_r - K_W'(1);
        end
      end
      L_SQR: begin
        frac_nxt = {frac_r[FRAC_W-2:0], t[32]};
        sh_nxt   = t[32] ? {t[32:1], 2'b00} : {t[31:0], 2'b00};
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'(FRAC_W - 1)) begin
          st_nxt   = L_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    sh_r   <= sh_nxt;
    k_r    <= k_nxt;
    frac_r <= frac_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done     = done_r;
  assign res.k    = k_r;
  assign res.frac = frac_r;
endmodule

FILE: src/bpl_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_term: log-ratio term unit
// Scales log2 to ln, then multiplies both counts by it one 16-bit digit per
// cycle and forms the s+b and b-only terms.
// ----------------------------------------------------------------------------
module bpl_term (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bpl_pkg::term_op_t   op,
  output logic                done,
  output bpl_pkg::term_res_t  res
);
  import bpl_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_ND   = 4'b0010,
    T_MUL  = 4'b0100,
    T_FIN  = 4'b1000
  } tstate_t;

  tstate_t     st_r, st_nxt;
  term_op_t    op_r, op_nxt;
  logic [31:0] nd_r, nd_nxt;
  logic        dig_r, dig_nxt;
  logic [63:0] acc_sb_r, acc_sb_nxt;
  logic [63:0] acc_b_r, acc_b_nxt;
  term_res_t   res_r, res_nxt;
  logic        done_r, done_nxt;
  logic [63:0] nd_prod;
  logic [DIG_W-1:0] digit;
  logic [63:0] rsb, rb;
  logic [39:0] s24;

  assign nd_prod = 64'(op_r.d) * 64'(LN2_Q32) + 64'h8000_0000;
  assign digit   = dig_r ? nd_r[DIG_W-1:0] : nd_r[2*DIG_W-1:DIG_W];
  assign rsb     = acc_sb_r + 64'h8000;
  assign rb      = acc_b_r + 64'h8000;
  assign s24     = {op_r.s, 8'h00};

  always_comb begin
    st_nxt     = st_r;
    op_nxt     = op_r;
    nd_nxt     = nd_r;
    dig_nxt    = dig_r;
    acc_sb_nxt = acc_sb_r;
    acc_b_nxt  = acc_b_r;
    res_nxt    = res_r;
    done_nxt   = done_r;
    unique case (st_r)
      T_IDLE: begin
        if (start) begin
          op_nxt   = op;
          done_nxt = 1'b0;
          st_nxt   = T_ND;
        end
      end
      T_ND: begin
        nd_nxt     = nd_prod[63:32];
        dig_nxt    = 1'b0;
        acc_sb_nxt = '0;
        acc_b_nxt  = '0;
        st_nxt     = T_MUL;
      end
      T_MUL: begin
        // high digit first, then shift and add the low digit
        acc_sb_nxt = {acc_sb_r[63-DIG_W:0], {DIG_W{1'b0}}}
                   + 64'(op_r.tot) * 64'(digit);
        acc_b_nxt  = {acc_b_r[63-DIG_W:0], {DIG_W{1'b0}}}
                   + 64'(op_r.b) * 64'(digit);
        dig_nxt    = 1'b1;
        if (dig_r) st_nxt = T_FIN;
      end
      T_FIN: begin
        res_nxt.sb = $signed({16'h0, s24}) - $signed({8'h0, rsb[63:16]});
        res_nxt.b  = $signed({16'h0, s24}) - $signed({8'h0, rb[63:16]});
        done_nxt   = 1'b1;
        st_nxt     = T_IDLE;
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= T_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    op_r     <= op_nxt;
    nd_r     <= nd_nxt;
    dig_r    <= dig_nxt;
    acc_sb_r <= acc_sb_nxt;
    acc_b_r  <= acc_b_nxt;
    res_r    <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

FILE: src/binned_poisson_llr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binned_poisson_llr: binned Poisson log-likelihood ratio
// Accumulates s+b and b-only Poisson log ratio terms over histogram bins and
// emits both sums and their difference on the last bin.
// ----------------------------------------------------------------------------
//  channel | dir | word                                    | accepted when
//  in_ch   | in  | back_count, sig_count, last_bin         | valid && ready
//  out_ch  | out | sb_sum, b_sum, delta_llr, overflow      | valid && ready
//
// An empty bin (zero background) is folded into the carried signal; if it is
// not the last, the input is ready again in the next cycle. A non-empty bin
// processes the previously held bin, if any: one-bit normalization plus
// squaring in the two log units, the term unit, an accumulate step and handoff.
// The last bin adds one more such pass. The serial normalizer and the squaring loop dominate.
// Reset (rst_n low, synchronous) clears all sums, held bin, saturation and valid flags.
// A waiting result sits in the output register; the next histogram is
// taken meanwhile, and only its own final write waits for out_ch.ready.
// ----------------------------------------------------------------------------
module binned_poisson_llr (
  input  logic      clk,
  input  logic      rst_n,
  bpl_in_if.sink    in_ch,
  bpl_out_if.source out_ch
);
  import bpl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOG   = 6'b000010,
    S_TERM  = 6'b000100,
    S_ACC   = 6'b001000,
    S_CARRY = 6'b010000,
    S_FINAL = 6'b100000
  } state_t;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  state_t           st_r, st_nxt;
  logic [CNT_W-1:0] carried_r, carried_nxt;
  logic [CNT_W-1:0] held_b_r, held_b_nxt;
  logic [CNT_W-1:0] held_s_r, held_s_nxt;
  logic             held_v_r, held_v_nxt;
  logic signed [SUM_W-1:0] sum_sb_r, sum_sb_nxt;
  logic signed [SUM_W-1:0] sum_b_r, sum_b_nxt;
  logic             sat_r, sat_nxt;
  logic [CNT_W-1:0] op_b_r, op_b_nxt;
  logic [CNT_W-1:0] op_s_r, op_s_nxt;
  logic             last_r, last_nxt;
  logic             second_r, second_nxt;
  logic             log_go_r, log_go_nxt;
  logic             term_go_r, term_go_nxt;
  logic [D_W-1:0]   d_r, d_nxt;
  logic             oval_r, oval_nxt;
  logic signed [SUM_W-1:0] osb_r, osb_nxt, ob_r, ob_nxt, odl_r, odl_nxt;
  logic             oovf_r, oovf_nxt;

  logic             in_acc;
  logic [CNT_W:0]   tot;
  logic             lt_done, lb_done, tm_done;
  log_res_t         lt_res, lb_res;
  term_op_t         tm_op;
  term_res_t        tm_res;
  logic [CNT_W:0]   add_hs, add_cs, add_ch;
  logic [K_W:0]     kd;
  logic signed [31:0] dd;
  logic signed [SUM_W+1:0] wsb, wb, wd;
  logic             hit_sb, hit_b, hit_d;

  function automatic logic signed [SUM_W-1:0] sat56(input logic signed [SUM_W+1:0] v);
    if (v > $signed({{2{SUM_MAX[SUM_W-1]}}, SUM_MAX})) return SUM_MAX;
    if (v < $signed({{2{SUM_MIN[SUM_W-1]}}, SUM_MIN})) return SUM_MIN;
    return v[SUM_W-1:0];
  endfunction

  function automatic logic out_of_range(input logic signed [SUM_W+1:0] v);
    return (v > $signed({{2{SUM_MAX[SUM_W-1]}}, SUM_MAX}))
        || (v < $signed({{2{SUM_MIN[SUM_W-1]}}, SUM_MIN}));
  endfunction

  assign in_acc = in_ch.valid && in_ch.ready;
  assign tot    = {1'b0, op_b_r} + {1'b0, op_s_r};

  // saturating adders for carried and held signal
  assign add_hs = {1'b0, in_ch.sig_count} + {1'b0, carried_r};
  assign add_cs = {1'b0, carried_r} + {1'b0, in_ch.sig_count};
  assign add_ch = {1'b0, held_s_r} + {1'b0, carried_r};

  // log ratio in Q8.24; integer parts' offsets cancel
  assign kd = {1'b0, lt_res.k} - {1'b0, lb_res.k};
  assign dd = $signed({kd[K_W], kd, 24'h0}) + $signed({8'h0, lt_res.frac})
            - $signed({8'h0, lb_res.frac});

  assign wsb = $signed({{2{sum_sb_r[SUM_W-1]}}, sum_sb_r})
             + $signed({{2{tm_res.sb[SUM_W-1]}}, tm_res.sb});
  assign wb  = $signed({{2{sum_b_r[SUM_W-1]}}, sum_b_r})
             + $signed({{2{tm_res.b[SUM_W-1]}}, tm_res.b});
  assign wd  = $signed({{2{sum_sb_r[SUM_W-1]}}, sum_sb_r})
             - $signed({{2{sum_b_r[SUM_W-1]}}, sum_b_r});
  assign hit_sb = out_of_range(wsb);
  assign hit_b  = out_of_range(wb);
  assign hit_d  = out_of_range(wd);

  assign tm_op.d   = d_r;
  assign tm_op.tot = tot;
  assign tm_op.b   = op_b_r;
  assign tm_op.s   = op_s_r;

  bpl_log u_log_tot (
    .clk(clk), .rst_n(rst_n), .start(log_go_r), .v(tot),
    .done(lt_done), .res(lt_res)
  );

  bpl_log u_log_back (
    .clk(clk), .rst_n(rst_n), .start(log_go_r), .v({1'b0, op_b_r}),
    .done(lb_done), .res(lb_res)
  );

  bpl_term u_term (
    .clk(clk), .rst_n(rst_n), .start(term_go_r), .op(tm_op),
    .done(tm_done), .res(tm_res)
  );

  always_comb begin
    st_nxt      = st_r;
    carried_nxt = carried_r;
    held_b_nxt  = held_b_r;
    held_s_nxt  = held_s_r;
    held_v_nxt  = held_v_r;
    sum_sb_nxt  = sum_sb_r;
    sum_b_nxt   = sum_b_r;
    sat_nxt     = sat_r;
    op_b_nxt    = op_b_r;
    op_s_nxt    = op_s_r;
    last_nxt    = last_r;
    second_nxt  = second_r;
    log_go_nxt  = 1'b0;
    term_go_nxt = 1'b0;
    d_nxt       = d_r;
    oval_nxt    = oval_r;
    osb_nxt     = osb_r;
    ob_nxt      = ob_r;
    odl_nxt     = odl_r;
    oovf_nxt    = oovf_r;

    // drop the shown word once taken
    if (out_ch.ready) oval_nxt = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          last_nxt   = in_ch.last_bin;
          second_nxt = 1'b0;
          if (in_ch.back_count != '0) begin
            // hand the previously held bin to the log units
            op_b_nxt    = held_b_r;
            op_s_nxt    = held_s_r;
            held_b_nxt  = in_ch.back_count;
            held_s_nxt  = add_hs[CNT_W] ? '1 : add_hs[CNT_W-1:0];
            if (add_hs[CNT_W]) sat_nxt = 1'b1;
            carried_nxt = '0;
            held_v_nxt  = 1'b1;
          end else begin
            carried_nxt = add_cs[CNT_W] ? '1 : add_cs[CNT_W-1:0];
            if (add_cs[CNT_W]) sat_nxt = 1'b1;
          end
          if (in_ch.back_count != '0 && held_v_r) begin
            log_go_nxt = 1'b1;
            st_nxt     = S_LOG;
          end else if (in_ch.last_bin) begin
            st_nxt = S_CARRY;
          end
        end
      end
      S_LOG: begin
        if (!log_go_r && lt_done && lb_done) begin
          d_nxt       = dd[31] ? '0 : dd[D_W-1:0];
          term_go_nxt = 1'b1;
          st_nxt      = S_TERM;
        end
      end
      S_TERM: begin
        if (!term_go_r && tm_done) st_nxt = S_ACC;
      end
      S_ACC: begin
        sum_sb_nxt = sat56(wsb);
        sum_b_nxt  = sat56(wb);
        if (hit_sb || hit_b) sat_nxt = 1'b1;
        priority if (second_r) st_nxt = S_FINAL;
        else if (last_r)       st_nxt = S_CARRY;
        else                   st_nxt = S_IDLE;
      end
      S_CARRY: begin
        // leftover signal joins the last non-empty bin
        if (held_v_r) begin
          op_b_nxt    = held_b_r;
          op_s_nxt    = add_ch[CNT_W] ? '1 : add_ch[CNT_W-1:0];
          held_s_nxt  = op_s_nxt;
          if (add_ch[CNT_W]) sat_nxt = 1'b1;
          carried_nxt = '0;
          second_nxt  = 1'b1;
          log_go_nxt  = 1'b1;
          st_nxt      = S_LOG;
        end else begin
          st_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        // hold until the output register is free
        if (!oval_r || out_ch.ready) begin
          oval_nxt    = 1'b1;
          osb_nxt     = sum_sb_r;
          ob_nxt      = sum_b_r;
          odl_nxt     = sat56(wd);
          oovf_nxt    = sat_r || hit_d;
          carried_nxt = '0;
          held_b_nxt  = '0;
          held_s_nxt  = '0;
          held_v_nxt  = 1'b0;
          sum_sb_nxt  = '0;
          sum_b_nxt   = '0;
          sat_nxt     = 1'b0;
          st_nxt      = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      carried_r <= '0;
      held_b_r  <= '0;
      held_s_r  <= '0;
      held_v_r  <= 1'b0;
      sum_sb_r  <= '0;
      sum_b_r   <= '0;
      sat_r     <= 1'b0;
      log_go_r  <= 1'b0;
      term_go_r <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      carried_r <= carried_nxt;
      held_b_r  <= held_b_nxt;
      held_s_r  <= held_s_nxt;
      held_v_r  <= held_v_nxt;
      sum_sb_r  <= sum_sb_nxt;
      sum_b_r   <= sum_b_nxt;
      sat_r     <= sat_nxt;
      log_go_r  <= log_go_nxt;
      term_go_r <= term_go_nxt;
      oval_r    <= oval_nxt;
    end
    op_b_r   <= op_b_nxt;
    op_s_r   <= op_s_nxt;
    last_r   <= last_nxt;
    second_r <= second_nxt;
    d_r      <= d_nxt;
    osb_r    <= osb_nxt;
    ob_r     <= ob_nxt;
    odl_r    <= odl_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign in_ch.ready      = (st_r == S_IDLE);
  assign out_ch.valid     = oval_r;
  assign out_ch.sb_sum    = osb_r;
  assign out_ch.b_sum     = ob_r;
  assign out_ch.delta_llr = odl_r;
  assign out_ch.overflow  = oovf_r;
endmodule

FILE: src/bpl_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_chk: port-level checks
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module bpl_chk (
  input logic       clk,
  input logic       rst_n,
  bpl_in_if.sink    in_ch,
  bpl_out_if.source out_ch
);
  // a stalled result word keeps valid, sb_sum and delta_llr stable
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.sb_sum)
      && $stable(out_ch.delta_llr))
    else $error("result word changed while stalled");

  // no result directly out of reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  // a last bin always starts end-of-histogram work
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.last_bin |=> !in_ch.ready)
    else $error("ready right after last bin");

  // an empty, non-final bin leaves the input ready in the next cycle
  a_empty_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && !in_ch.last_bin && in_ch.back_count == 32'd0
      |=> in_ch.ready)
    else $error("empty bin stalled input");
endmodule

bind binned_poisson_llr bpl_chk u_bpl_chk (
  .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
);
